/* src/fsl_pkg.sv */
// ----------------------------------------------------------------------------
// fsl_pkg
// Shared types and constants for the floor-sum block.
// ----------------------------------------------------------------------------
package fsl_pkg;

  localparam int OUT_W = 60;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_ROUND   = 11'b00000000010,
    S_DIV     = 11'b00000000100,
    S_MUL_TRI = 11'b00000001000,
    S_MUL_LO  = 11'b00000010000,
    S_ADD_LO  = 11'b00000100000,
    S_ADD_HI  = 11'b00001000000,
    S_MUL_NB  = 11'b00010000000,
    S_TOP_MUL = 11'b00100000000,
    S_TOP_ADD = 11'b01000000000,
    S_DONE    = 11'b10000000000
  } state_t;

  typedef enum logic [1:0] {
    TAG_A   = 2'd0,
    TAG_B   = 2'd1,
    TAG_TOP = 2'd2
  } div_tag_t;

endpackage

/* src/floor_sum_linear.sv */
// ----------------------------------------------------------------------------
// floor_sum_linear
// Sum of floor((slope*x + offset) / divisor) for x = 0 .. term_count-1,
// by the Euclidean reduction on one shared divider and one shared multiplier.
//
//   channel  | handshake          | fields
//   ---------+--------------------+---------------------------------------
//   query in | start, busy        | term_count, divisor, slope, offset
//   result   | valid (one cycle)  | floor_sum
//
// Each reduction round takes up to two short divides, one restoring divide of
// the top term, and the sequencing, multiply and add states between them.
// The reduction ends in fewer than 32 rounds at the default sizes (MAX_TERMS
// only caps it). busy is high from the cycle after acceptance through the
// result cycle. rst is synchronous and returns to idle.
// The receiver cannot stall: valid is high for exactly one cycle.
// ----------------------------------------------------------------------------
module floor_sum_linear
  import fsl_pkg::*;
#(
  parameter int IN_BITS   = 20,
  parameter int MAX_TERMS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [IN_BITS-1:0] term_count,
  input  logic [IN_BITS-1:0] divisor,
  input  logic [IN_BITS-1:0] slope,
  input  logic [IN_BITS-1:0] offset,
  output logic               valid,
  output logic [OUT_W-1:0]   floor_sum
);

  localparam int W  = IN_BITS;
  localparam int DW = 2 * W + 1;
  localparam int CW = $clog2(DW + 1);
  localparam int RW = $clog2(MAX_TERMS + 1);

  state_t           state;
  div_tag_t         tag;
  logic [W-1:0]     n, m, a, b;
  logic [OUT_W-1:0] acc;
  logic [2*W-1:0]   prod;
  logic [W-2:0]     tri_hi;
  logic [DW-1:0]    quo;
  logic [W-1:0]     rem;
  logic [CW-1:0]    cnt;
  logic [RW-1:0]    round;

  // divider step
  logic [W:0]       trial;
  logic             trial_ge;
  logic [W-1:0]     rem_next;
  logic [DW-1:0]    top;
  logic [W-1:0]     mul_x, mul_y;

  assign trial    = {rem, quo[DW-1]};
  assign trial_ge = trial >= {1'b0, m};
  assign rem_next = trial_ge ? W'(trial - {1'b0, m}) : trial[W-1:0];
  assign top      = DW'(prod) + DW'(b);

  always_comb begin
    mul_x = n;
    mul_y = quo[W-1:0];
    case (state)
      S_MUL_TRI: begin
        mul_x = n;
        mul_y = n - 1'b1;
      end
      S_MUL_LO: begin
        mul_x = prod[W:1];
        mul_y = quo[W-1:0];
      end
      S_ADD_LO: begin
        mul_x = {1'b0, tri_hi};
        mul_y = quo[W-1:0];
      end
      S_TOP_MUL: begin
        mul_x = a;
        mul_y = n;
      end
      default: begin
        mul_x = n;
        mul_y = quo[W-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tag   <= TAG_A;
      cnt   <= '0;
      round <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            n     <= term_count;
            m     <= divisor;
            a     <= slope;
            b     <= offset;
            acc   <= '0;
            round <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          rem <= '0;
          if (m == '0 || round == RW'(MAX_TERMS)) begin
            state <= S_DONE;
          end else if (a >= m) begin
            quo   <= DW'(a) << (W + 1);
            cnt   <= CW'(W);
            tag   <= TAG_A;
            state <= S_DIV;
          end else if (b >= m) begin
            quo   <= DW'(b) << (W + 1);
            cnt   <= CW'(W);
            tag   <= TAG_B;
            state <= S_DIV;
          end else begin
            state <= S_TOP_MUL;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= {quo[DW-2:0], trial_ge};
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            case (tag)
              TAG_A:   state <= S_MUL_TRI;
              TAG_B:   state <= S_MUL_NB;
              TAG_TOP: begin
                // swap axes: next count is the top quotient
                n     <= {quo[W-2:0], trial_ge};
                b     <= rem_next;
                m     <= a;
                a     <= m;
                round <= round + 1'b1;
                state <= S_ROUND;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_MUL_TRI: begin
          a     <= rem;
          prod  <= mul_x * mul_y;
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          tri_hi <= prod[2*W-1:W+1];
          prod   <= mul_x * mul_y;
          state  <= S_ADD_LO;
        end
        S_ADD_LO: begin
          acc   <= acc + OUT_W'(prod);
          prod  <= mul_x * mul_y;
          state <= S_ADD_HI;
        end
        S_ADD_HI: begin
          acc <= acc + (OUT_W'(prod) << W);
          rem <= '0;
          if (b >= m) begin
            quo   <= DW'(b) << (W + 1);
            cnt   <= CW'(W);
            tag   <= TAG_B;
            state <= S_DIV;
          end else begin
            state <= S_TOP_MUL;
          end
        end
        S_MUL_NB: begin
          b     <= rem;
          prod  <= mul_x * mul_y;
          state <= S_TOP_MUL;
          acc   <= acc;
        end
        S_TOP_MUL: begin
          // the n*q product from the offset step lands here when it ran
          if (tag == TAG_B) begin
            acc <= acc + OUT_W'(prod);
            tag <= TAG_TOP;
          end
          prod  <= mul_x * mul_y;
          state <= S_TOP_ADD;
        end
        S_TOP_ADD: begin
          rem <= '0;
          if (top < DW'(m)) begin
            state <= S_DONE;
          end else begin
            quo   <= top;
            cnt   <= CW'(DW);
            tag   <= TAG_TOP;
            state <= S_DIV;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy      = state != S_IDLE;
  assign valid     = state == S_DONE;
  assign floor_sum = acc;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    valid |=> !busy) else $error("result not followed by idle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !valid) else $error("accepted item did not start");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < m) else $error("divider remainder out of range");
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> round <= RW'(MAX_TERMS)) else $error("round budget exceeded");
`endif

endmodule
